### rtl/core/imm_pkg.sv
// Shared types, codes and helpers for the interpolating mixing matrix.
`timescale 1ns / 1ps
package imm_pkg;

  localparam int MaxChannelsDef = 8;

  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_COMMIT  = 3'd1,
    ACT_READ    = 3'd2,
    ACT_PRELOAD = 3'd3,
    ACT_SAMPLE  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_COMMIT,
    OP_READ,
    OP_PRELOAD,
    OP_SAMPLE
  } op_e;

  typedef enum logic [2:0] {
    REG_GAIN_SCALE  = 3'd0,
    REG_OUT_COUNT   = 3'd1,
    REG_IN_COUNT    = 3'd2,
    REG_RAMP_FACTOR = 3'd3,
    REG_THRESHOLD   = 3'd4,
    REG_RAMP_STEPS  = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_RD_EMIT,
    ST_CM_RD,
    ST_CM_MUL,
    ST_CM_GAP,
    ST_CM_WR,
    ST_CM_DONE,
    ST_SM_RD,
    ST_SM_MUL,
    ST_SM_WR,
    ST_SM_END,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [2:0]         row_index;
    logic [2:0]         coeff_index;
    logic signed [23:0] value;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] result_value;
    logic [2:0]         result_channel;
    logic signed [15:0] step_count;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [23:0] value;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] gain_scale;
    logic [3:0]         out_count;
    logic [3:0]         in_count;
    logic [15:0]        ramp_factor;
    logic [30:0]        change_threshold;
    logic [14:0]        ramp_steps;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sd2147483647) return 32'sh7fffffff;
    if (x < -34'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
    if (x > 32'sd8388607) return 24'sh7fffff;
    if (x < -32'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

endpackage

### rtl/core/imm_front.sv
// Front end: accepts items, decodes the action and queues commands.
`timescale 1ns / 1ps
module imm_front
  import imm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_item_t item,
  input  logic     clearing,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       decoded;

  always_comb begin
    decoded.row   = item.row_index;
    decoded.col   = item.coeff_index;
    decoded.value = item.value;
    decoded.last  = item.last_sample;
    case (item.action)
      ACT_WRITE:   decoded.op = OP_WRITE;
      ACT_COMMIT:  decoded.op = OP_COMMIT;
      ACT_READ:    decoded.op = OP_READ;
      ACT_PRELOAD: decoded.op = OP_PRELOAD;
      ACT_SAMPLE:  decoded.op = OP_SAMPLE;
      default:     decoded.op = OP_NONE;
    endcase
  end

  assign item_stall = (count == 2'd2) || clearing;
  assign push       = item_valid && !item_stall;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= decoded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (cmd_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

### rtl/core/imm_back.sv
// Back end: coefficient stores, accumulators, sequencer and result register.
`timescale 1ns / 1ps
module imm_back
  import imm_pkg::*;
#(
  parameter int MaxCh = MaxChannelsDef
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      clearing,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  localparam int Cells = MaxCh * MaxCh;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int CW    = $clog2(MaxCh + 1);
  localparam int IW    = (MaxCh > 1) ? $clog2(MaxCh) : 1;
  localparam int SumW  = 33 + AW;

  state_e state, state_next;

  logic signed [23:0] tgt_mem [Cells];
  logic signed [31:0] cur_mem [Cells];
  logic signed [31:0] dlt_mem [Cells];
  logic signed [23:0] tgt_q;
  logic signed [31:0] cur_q, dlt_q;

  logic signed [31:0] acc [MaxCh];
  logic [AW-1:0]      clr_addr;
  cmd_t               cmd_r;
  logic [CW-1:0]      r_cnt, c_cnt;
  logic [CW-1:0]      rows, cols;
  logic               rd_ok;
  logic [15:0]        ramp_cnt;
  logic [SumW-1:0]    sum;

  logic signed [47:0] prod_a;
  logic signed [49:0] prod_b;
  logic signed [55:0] prod_s;
  logic signed [31:0] cur_hold, dlt_hold;

  logic [AW-1:0]      rd_addr, wr_addr;
  logic               tgt_we, cur_we, dlt_we;
  logic signed [23:0] tgt_wd;
  logic signed [31:0] cur_wd, dlt_wd;

  logic               slot_free;
  logic               load_result;
  logic               c_last, r_last;
  logic signed [32:0] gap;
  logic signed [31:0] d_sat, p_shift;
  logic signed [32:0] d_abs;
  logic               wr_in_range;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * MaxCh + 32'(c));
  endfunction

  assign rows = (32'(cfg.out_count) > MaxCh) ? CW'(MaxCh) : CW'(cfg.out_count);
  assign cols = (32'(cfg.in_count) > MaxCh) ? CW'(MaxCh) : CW'(cfg.in_count);

  assign slot_free   = !result_valid || !result_stall;
  assign load_result = ((state == ST_RD_EMIT) || (state == ST_EMIT)) && slot_free;
  assign c_last      = (c_cnt + CW'(1)) == cols;
  assign r_last      = (r_cnt + CW'(1)) == rows;
  assign gap         = 33'($signed(prod_a[47:16])) - 33'(cur_hold);
  assign d_sat       = sat32(prod_b[49:16]);
  assign d_abs       = (d_sat < 0) ? -33'(d_sat) : 33'(d_sat);
  assign p_shift     = prod_s[55:24];
  assign clearing    = (state == ST_CLEAR);
  assign wr_in_range = (32'(cmd_r.row) < MaxCh) && (32'(cmd_r.col) < MaxCh);

  // Read address per state; the read data is registered and comes back in the next cycle.
  always_comb begin
    case (state)
      ST_RD_WAIT, ST_RD_EMIT:       rd_addr = addr_of(CW'(cmd_r.row), CW'(cmd_r.col));
      ST_SM_RD, ST_SM_MUL, ST_SM_WR: rd_addr = addr_of(r_cnt, CW'(cmd_r.col));
      default:                      rd_addr = addr_of(r_cnt, c_cnt);
    endcase
  end

  always_comb begin
    tgt_we  = 1'b0;
    cur_we  = 1'b0;
    dlt_we  = 1'b0;
    tgt_wd  = cmd_r.value;
    cur_wd  = sat32(34'(cur_hold) + 34'(dlt_hold));
    dlt_wd  = d_sat;
    wr_addr = rd_addr;
    case (state)
      ST_CLEAR: begin
        tgt_we  = 1'b1;
        cur_we  = 1'b1;
        dlt_we  = 1'b1;
        tgt_wd  = '0;
        cur_wd  = '0;
        dlt_wd  = '0;
        wr_addr = clr_addr;
      end
      ST_EXEC: begin
        tgt_we  = (cmd_r.op == OP_WRITE) && wr_in_range;
        wr_addr = addr_of(CW'(cmd_r.row), CW'(cmd_r.col));
      end
      ST_CM_WR: dlt_we = 1'b1;
      ST_SM_WR: cur_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[wr_addr] <= tgt_wd;
    if (cur_we) cur_mem[wr_addr] <= cur_wd;
    if (dlt_we) dlt_mem[wr_addr] <= dlt_wd;
    tgt_q <= tgt_mem[rd_addr];
    cur_q <= cur_mem[rd_addr];
    dlt_q <= dlt_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    case (state)
      ST_CLEAR: if (clr_addr == AW'(Cells - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_r.op)
          OP_READ:   state_next = ST_RD_WAIT;
          OP_COMMIT: state_next = (rows == '0 || cols == '0) ? ST_CM_DONE : ST_CM_RD;
          OP_SAMPLE: state_next = (32'(cmd_r.col) < 32'(cols) && rows != '0) ?
                                  ST_SM_RD : ST_SM_END;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_RD_WAIT: state_next = ST_RD_EMIT;
      ST_RD_EMIT: if (slot_free) state_next = ST_IDLE;
      ST_CM_RD:   state_next = ST_CM_MUL;
      ST_CM_MUL:  state_next = ST_CM_GAP;
      ST_CM_GAP:  state_next = ST_CM_WR;
      ST_CM_WR:   state_next = (c_last && r_last) ? ST_CM_DONE : ST_CM_RD;
      ST_CM_DONE: state_next = ST_IDLE;
      ST_SM_RD:   state_next = ST_SM_MUL;
      ST_SM_MUL:  state_next = ST_SM_WR;
      ST_SM_WR:   state_next = r_last ? ST_SM_END : ST_SM_RD;
      ST_SM_END:  state_next = (cmd_r.last && rows != '0) ? ST_EMIT : ST_IDLE;
      ST_EMIT:    if (slot_free && r_last) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Datapath and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      ramp_cnt     <= '0;
      result_valid <= 1'b0;
      r_cnt        <= '0;
      c_cnt        <= '0;
      sum          <= '0;
      for (int i = 0; i < MaxCh; i++) acc[i] <= '0;
    end else begin
      if (load_result) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        ST_IDLE: if (cmd_valid) cmd_r <= cmd;
        ST_EXEC: begin
          r_cnt <= '0;
          c_cnt <= '0;
          sum   <= '0;
          rd_ok <= (32'(cmd_r.row) < 32'(rows)) && (32'(cmd_r.col) < 32'(cols));
          if (cmd_r.op == OP_PRELOAD && 32'(cmd_r.row) < MaxCh)
            acc[IW'(cmd_r.row)] <= 32'(cmd_r.value);
        end
        ST_RD_EMIT: begin
          if (slot_free) begin
            result.result_value   <= rd_ok ? tgt_q : '0;
            result.result_channel <= cmd_r.row;
            result.step_count     <= ramp_cnt;
            result.last_result    <= 1'b1;
          end
        end
        ST_CM_MUL: begin
          prod_a   <= tgt_q * cfg.gain_scale;
          cur_hold <= cur_q;
        end
        ST_CM_GAP: prod_b <= gap * $signed({1'b0, cfg.ramp_factor});
        ST_CM_WR: begin
          sum <= sum + SumW'(d_abs[31:0]);
          if (c_last) begin
            c_cnt <= '0;
            r_cnt <= r_cnt + CW'(1);
          end else begin
            c_cnt <= c_cnt + CW'(1);
          end
        end
        ST_CM_DONE: begin
          if (sum > SumW'({cfg.change_threshold, 4'b0000}))
            ramp_cnt <= 16'(cfg.ramp_steps);
        end
        ST_SM_MUL: begin
          prod_s   <= cmd_r.value * cur_q;
          cur_hold <= cur_q;
          dlt_hold <= dlt_q;
        end
        ST_SM_WR: begin
          acc[IW'(r_cnt)] <= sat32(34'(acc[IW'(r_cnt)]) + 34'(p_shift));
          r_cnt <= r_cnt + CW'(1);
        end
        ST_SM_END: begin
          r_cnt <= '0;
          if (cmd_r.last) ramp_cnt <= ramp_cnt - 16'd1;
        end
        ST_EMIT: begin
          if (slot_free) begin
            result.result_value   <= sat24(acc[IW'(r_cnt)]);
            result.result_channel <= 3'(r_cnt);
            result.step_count     <= ramp_cnt;
            result.last_result    <= r_last;
            acc[IW'(r_cnt)]       <= '0;
            r_cnt                 <= r_cnt + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/interpolating_mixing_matrix_top.sv
// A read emits one result; a commit steps through every active cell and a sample
// through every active row, and a last sample then emits one result per active row.
// Throughput: one item at a time in the back end, set by its shared multiply
// sequencer; a two-entry command queue lets the input side run ahead.
// After reset a clearing pass zeroes every cell of the coefficient stores;
// no item is taken during it. Registers reset to defaults.
`timescale 1ns / 1ps
module interpolating_mixing_matrix_top
  import imm_pkg::*;
#(
  parameter int MaxCh = MaxChannelsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  cfg_t cfg;
  logic clearing;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_scale       <= 24'sd1048576;
      cfg.out_count        <= 4'd8;
      cfg.in_count         <= 4'd8;
      cfg.ramp_factor      <= 16'd2048;
      cfg.change_threshold <= '0;
      cfg.ramp_steps       <= 15'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_SCALE:  cfg.gain_scale       <= cfg_data[23:0];
        REG_OUT_COUNT:   cfg.out_count        <= cfg_data[3:0];
        REG_IN_COUNT:    cfg.in_count         <= cfg_data[3:0];
        REG_RAMP_FACTOR: cfg.ramp_factor      <= cfg_data[15:0];
        REG_THRESHOLD:   cfg.change_threshold <= cfg_data;
        REG_RAMP_STEPS:  cfg.ramp_steps       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  imm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .clearing   (clearing),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  imm_back #(.MaxCh(MaxCh)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
